/* rtl/core/bsfr_pkg.sv */
`timescale 1ns / 1ps

package bsfr_pkg;

    // stuffing codes
    localparam logic [7:0] ESC_BYTE   = 8'h61;
    localparam logic [7:0] END_BYTE   = 8'h62;
    localparam logic [7:0] START_BYTE = 8'h63;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int OUT_W  = 16;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_START,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CMD,
        BK_RD,
        BK_OUT
    } back_state_t;

endpackage

/* rtl/core/byte_stuffed_frame_receiver.sv */
`timescale 1ns / 1ps

// Byte-stuffed frame receiver.
// Slave channel s_*: one raw serial byte per word. Escape 'a' then 'c' opens
// a frame, 'a' 'b' closes it, 'a' 'a' is a literal 'a', 'a' plus any other
// byte keeps that byte. Bytes outside a frame are dropped.
// Master channel m_*: when a non-empty frame closes, its payload comes out
// one byte per word with length and overflow flag; m_tlast marks the final
// byte. Frames longer than DEPTH-1 keep overwriting the last slot and are
// flagged as overflowed.
// The front end unstuffs each word in its accept cycle and queues a command
// in a 4-entry queue; the back end drains one command per cycle while it is
// not emitting a frame. Throughput: one input word per cycle while the queue
// has room. A closing frame holds the back end while, for each byte, it reads
// the frame store (BK_RD) and then loads the output register (BK_OUT), since
// the store read is registered; BK_OUT waits while m_* is stalled.
// If m_tready stays low the back end stops, the queue fills, and s_tready
// drops once it is full. Reset (aresetn low, synchronous) empties
// the queue, closes any open frame and clears m_tvalid; the store needs no
// clearing.

module byte_stuffed_frame_receiver import bsfr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [7:0] frame_byte, [14:8] frame_length, [15] overflowed
    output logic              m_tlast    // last_byte
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    bsfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd)
    );

    bsfr_cmd_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd)
    );

    bsfr_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_cmd  (pop_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/bsfr_ram.sv */
`timescale 1ns / 1ps

module bsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bsfr_front.sv */
`timescale 1ns / 1ps

module bsfr_front import bsfr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,    // [7:0] rx_byte
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_cmd
);

    logic in_frame_reg, in_frame_next;
    logic esc_reg, esc_next;
    logic accept;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;

    // unstuff and classify one word
    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        push_valid    = 1'b0;
        push_cmd.kind = CMD_STORE;
        push_cmd.data = s_tdata;
        if (accept) begin
            if (s_tdata == ESC_BYTE) begin
                esc_next = !esc_reg;
                // doubled escape is a literal
                push_valid = esc_reg && in_frame_reg;
            end else if (esc_reg && s_tdata == START_BYTE) begin
                esc_next      = 1'b0;
                in_frame_next = 1'b1;
                push_valid    = 1'b1;
                push_cmd.kind = CMD_START;
            end else if (esc_reg && s_tdata == END_BYTE) begin
                esc_next      = 1'b0;
                in_frame_next = 1'b0;
                // end marker outside a frame is dropped
                push_valid    = in_frame_reg;
                push_cmd.kind = CMD_END;
            end else begin
                esc_next   = 1'b0;
                push_valid = in_frame_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
        end
    end

endmodule

/* rtl/core/bsfr_cmd_fifo.sv */
`timescale 1ns / 1ps

module bsfr_cmd_fifo import bsfr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/bsfr_back.sv */
`timescale 1ns / 1ps

module bsfr_back import bsfr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  cmd_t             pop_cmd,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [7:0] frame_byte, [14:8] frame_length, [15] overflowed
    output logic             m_tlast    // last_byte
);

    localparam int AW = $clog2(DEPTH);

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW:0]       fill_inc;
    logic              ram_we, ram_re, load_out, out_free, idx_last;
    logic [BYTE_W-1:0] ram_rdata;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg;

    bsfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(fill_reg),
        .wdata(pop_cmd.data),
        .re   (ram_re),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_last = idx_reg == fill_reg - 1'b1;
    assign fill_inc = {1'b0, fill_reg} + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CMD: begin
                if (pop_valid && pop_cmd.kind == CMD_END && fill_reg != '0) begin
                    state_next = BK_RD;
                end
            end
            BK_RD: begin
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next = idx_last ? BK_CMD : BK_RD;
                end
            end
            default: begin
                state_next = BK_CMD;
            end
        endcase
    end

    // control outputs and datapath updates
    always_comb begin
        pop_ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        load_out  = 1'b0;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        idx_next  = idx_reg;
        case (state_reg)
            BK_CMD: begin
                pop_ready = 1'b1;
                idx_next  = '0;
                if (pop_valid) begin
                    case (pop_cmd.kind)
                        CMD_STORE: begin
                            ram_we = 1'b1;
                            // store full: hold at the last slot
                            if (fill_inc == (AW+1)'(DEPTH)) begin
                                ovf_next = 1'b1;
                            end else begin
                                fill_next = fill_inc[AW-1:0];
                            end
                        end
                        CMD_START: begin
                            fill_next = '0;
                            ovf_next  = 1'b0;
                        end
                        CMD_END: begin
                            // empty frame: nothing to emit
                            if (fill_reg == '0) begin
                                ovf_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_RD: begin
                ram_re = 1'b1;
            end
            BK_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (idx_last) begin
                        fill_next = '0;
                        ovf_next  = 1'b0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {ovf_reg, LEN_W'(fill_reg), ram_rdata};
            m_tlast_reg <= idx_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CMD;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/core/bsfr_checker.sv */
`timescale 1ns / 1ps

module bsfr_checker import bsfr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tlast
);

    // reset leaves no word on the master side
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // emitted frames are never empty
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:8] != 7'd0)
        else $error("zero frame length");

    // overflowed frames report the clamped length
    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> m_tdata[14:8] == LEN_W'(DEPTH - 1))
        else $error("overflow with wrong length");

    // length and flag stay the same across one frame
    a_frame_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
        !m_tvalid || m_tdata[15:8] == $past(m_tdata[15:8]))
        else $error("frame header changed inside a frame");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker #(.DEPTH(DEPTH)) u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

/* verif/byte_stuffed_frame_receiver_tb.sv */
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_tb;
    import bsfr_pkg::*;

    localparam int FRAME_DEPTH = 64;
    localparam int HALF_PERIOD = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_WORDS  = 40;
    localparam int SETTLE_CYCLES = 40;

    // one raw serial byte waiting to be sent; drain_first holds it back
    // until every pending payload byte has come out
    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                drain_first;
    } rx_word_t;

    // one payload byte as it should appear on the master side
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              ovf;
        logic              last;
    } frame_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    rx_word_t    rx_words_q[$];
    frame_word_t frame_words_q[$];

    // unstuffing state of the predictor
    bit                deframe_open;
    bit                deframe_esc;
    int                deframe_fill;
    bit                deframe_ovf;
    logic [BYTE_W-1:0] deframe_store [FRAME_DEPTH];

    int mismatches = 0;
    int words_in   = 0;
    bit s_fire     = 1'b0;
    bit tail_mode  = 1'b0;
    bit hold_rx    = 1'b0;
    bit tx_busy    = 1'b1;
    bit rx_busy    = 1'b1;
    int tx_gap     = 0;
    int rx_stall   = 0;

    byte_stuffed_frame_receiver #(
        .DEPTH(FRAME_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),      // [7:0] rx_byte
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),      // [7:0] frame_byte, [14:8] frame_length, [15] overflowed
        .m_tlast(m_tlast)       // last_byte
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // write one payload byte into the store, pinning the count at the last slot
    function automatic void store_payload(input logic [BYTE_W-1:0] rx);
        if (!deframe_open) return;
        deframe_store[deframe_fill] = rx;
        if (deframe_fill + 1 >= FRAME_DEPTH) begin
            deframe_fill = FRAME_DEPTH - 1;
            deframe_ovf  = 1'b1;
        end else begin
            deframe_fill = deframe_fill + 1;
        end
    endfunction

    // unstuff one accepted byte; a closing marker queues the whole frame
    function automatic void unstuff_byte(input logic [BYTE_W-1:0] rx);
        frame_word_t fw;
        if (rx == ESC_BYTE) begin
            if (!deframe_esc) begin
                deframe_esc = 1'b1;
                return;
            end
            deframe_esc = 1'b0;
            store_payload(rx);
            return;
        end
        if (deframe_esc) begin
            deframe_esc = 1'b0;
            if (rx == START_BYTE) begin
                deframe_open = 1'b1;
                deframe_fill = 0;
                deframe_ovf  = 1'b0;
                return;
            end
            if (rx == END_BYTE) begin
                if (deframe_open) begin
                    for (int k = 0; k < deframe_fill; k++) begin
                        fw.data = deframe_store[k];
                        fw.len  = LEN_W'(deframe_fill);
                        fw.ovf  = deframe_ovf;
                        fw.last = (k + 1 == deframe_fill);
                        frame_words_q.push_back(fw);
                    end
                end
                deframe_open = 1'b0;
                deframe_fill = 0;
                deframe_ovf  = 1'b0;
                return;
            end
        end
        store_payload(rx);
    endfunction

    function automatic void push_word(input logic [BYTE_W-1:0] rx, input bit drain);
        rx_word_t w;
        w.rx          = rx;
        w.drain_first = drain;
        rx_words_q.push_back(w);
    endfunction

    // random payload byte, stuffed where needed; now and then a redundant escape
    function automatic void push_payload();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        if (b == ESC_BYTE) begin
            push_word(ESC_BYTE, 1'b0);
            push_word(ESC_BYTE, 1'b0);
        end else if ($urandom_range(0, 9) == 0) begin
            push_word(ESC_BYTE, 1'b0);
            push_word((b == END_BYTE || b == START_BYTE) ? 8'h64 : b, 1'b0);
        end else begin
            push_word(b, 1'b0);
        end
    endfunction

    // well-formed frame with len payload bytes
    function automatic void push_frame(input int len, input bit drain);
        push_word(ESC_BYTE, drain);
        push_word(START_BYTE, 1'b0);
        for (int i = 0; i < len; i++) push_payload();
        push_word(ESC_BYTE, 1'b0);
        push_word(END_BYTE, 1'b0);
    endfunction

    // sender: offers the next queued byte at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // word still waiting for s_tready
        end else if (tx_gap > 0) begin
            tx_gap   <= tx_gap - 1;
            s_tvalid <= 1'b0;
        end else if (rx_words_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (rx_words_q[0].drain_first && frame_words_q.size() != 0) begin
            s_tvalid <= 1'b0;
        end else if (!tail_mode && tx_busy && $urandom_range(0, 5) == 0) begin
            tx_gap   <= $urandom_range(0, 15);
            s_tvalid <= 1'b0;
        end else begin
            s_tdata  <= rx_words_q[0].rx;
            s_tvalid <= 1'b1;
            void'(rx_words_q.pop_front());
        end
        tail_mode <= rx_words_q.size() < TAIL_WORDS;
        if ($urandom_range(0, 63) == 0) tx_busy <= ~tx_busy;
    end

    // receiver: random back-pressure bursts plus the long hold-off
    always @(negedge aclk) begin
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!tail_mode && rx_busy && $urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 63) == 0) rx_busy <= ~rx_busy;
    end

    // monitor: check output words, then predict on accepted input words
    always @(posedge aclk) begin
        frame_word_t expected_word;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (frame_words_q.size() == 0) begin
                    $error("unexpected output word: frame_byte %0h", m_tdata[BYTE_W-1:0]);
                    mismatches++;
                end else begin
                    expected_word = frame_words_q.pop_front();
                    if (m_tdata[BYTE_W-1:0] !== expected_word.data) begin
                        $error("frame_byte: expected %0h, got %0h",
                               expected_word.data, m_tdata[BYTE_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[BYTE_W+LEN_W-1:BYTE_W] !== expected_word.len) begin
                        $error("frame_length: expected %0d, got %0d",
                               expected_word.len, m_tdata[BYTE_W+LEN_W-1:BYTE_W]);
                        mismatches++;
                    end
                    if (m_tdata[BYTE_W+LEN_W] !== expected_word.ovf) begin
                        $error("overflowed: expected %0b, got %0b",
                               expected_word.ovf, m_tdata[BYTE_W+LEN_W]);
                        mismatches++;
                    end
                    if (m_tlast !== expected_word.last) begin
                        $error("last_byte: expected %0b, got %0b", expected_word.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                unstuff_byte(s_tdata);
                words_in++;
            end
        end
        s_fire <= aresetn && s_tvalid && s_tready;
    end

    // long receiver hold-off while a frame is draining, so the input stalls
    initial begin
        while (!(words_in >= 150 && frame_words_q.size() > 1)) @(negedge aclk);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] directed [];
        int sel;

        directed = '{
            // idle: stray byte, end marker with no frame, escaped byte
            8'h5A, ESC_BYTE, END_BYTE, ESC_BYTE, 8'h10,
            // frame with extremes, literal escape and redundant escape
            ESC_BYTE, START_BYTE, 8'h00, 8'hFF, ESC_BYTE, ESC_BYTE,
            ESC_BYTE, 8'h10, ESC_BYTE, END_BYTE,
            // empty frame
            ESC_BYTE, START_BYTE, ESC_BYTE, END_BYTE,
            // restart inside an open frame discards it
            ESC_BYTE, START_BYTE, 8'h55, ESC_BYTE, START_BYTE, 8'hAA,
            ESC_BYTE, END_BYTE
        };

        deframe_open = 1'b0;
        deframe_esc  = 1'b0;
        deframe_fill = 0;
        deframe_ovf  = 1'b0;

        foreach (directed[i]) push_word(directed[i], 1'b0);
        // store overflow, sent only once the earlier frames are out
        push_frame(70, 1'b1);

        while (rx_words_q.size() < 300) begin
            sel = $urandom_range(0, 39);
            if (sel == 0) begin
                push_frame($urandom_range(55, 70), 1'b0);
            end else if (sel < 30) begin
                push_frame($urandom_range(0, 12), $urandom_range(0, 24) == 0);
            end else if (sel < 35) begin
                // noise between frames, sometimes a stray end marker
                repeat ($urandom_range(1, 6)) push_word(BYTE_W'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1) == 0) begin
                    push_word(ESC_BYTE, 1'b0);
                    push_word(END_BYTE, 1'b0);
                end
            end else begin
                // frame cut short by the next start marker
                push_word(ESC_BYTE, 1'b0);
                push_word(START_BYTE, 1'b0);
                repeat ($urandom_range(0, 8)) push_word(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (rx_words_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (frame_words_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
